### hw/rtl/gbb_pkg.sv
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared types, constants and helpers of the glyph grid ink bounding box.
// ----------------------------------------------------------------------------
`default_nettype none

package gbb_pkg;

   localparam int CELLS_PER_AXIS = 16;
   localparam int POS_W          = 12;   // image coordinate width, 4096 pixels
   localparam int PITCH_W        = 9;    // cell pitch, up to 256
   localparam int OFF_W          = 8;    // offset inside a cell
   localparam int SIZE_W         = 10;   // signed box size
   localparam int CSR_DATA_W     = 12;
   localparam int CSR_IDX_W      = 2;

   localparam logic [PITCH_W-1:0] PITCH_MIN   = PITCH_W'(2);
   localparam logic [PITCH_W-1:0] PITCH_MAX   = PITCH_W'(256);
   localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_X0 = 2'd0,
      CSR_FRAME_Y0 = 2'd1,
      CSR_PITCH_X  = 2'd2,
      CSR_PITCH_Y  = 2'd3
   } csr_index_type;

   // Result of placing one coordinate on the grid.
   typedef struct packed {
      logic             ok;       // inside a cell, not on its last column/row
      logic [OFF_W-1:0] offset;   // cell-relative coordinate
   } loc_type;

   // One located pixel handed to the tracker stage.
   typedef struct packed {
      logic             hit;
      logic             last;
      logic [OFF_W-1:0] col;
      logic [OFF_W-1:0] row;
   } pix_type;

   function automatic logic [PITCH_W-1:0] eff_pitch(input logic [PITCH_W-1:0] p);
      logic [PITCH_W-1:0] r;
      r = p;
      if (p < PITCH_MIN) begin
         r = PITCH_MIN;
      end else if (p > PITCH_MAX) begin
         r = PITCH_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gbb_locate.sv
// ----------------------------------------------------------------------------
// gbb_locate
// Places one image coordinate on the cell grid: cell-relative offset and a
// flag for "inside a cell and not on its last column or row".
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_locate (
   input  logic [gbb_pkg::POS_W-1:0]   pos,
   input  logic [gbb_pkg::POS_W-1:0]   origin,
   input  logic [gbb_pkg::PITCH_W-1:0] pitch,
   output gbb_pkg::loc_type            loc
);
   import gbb_pkg::*;

   logic [POS_W-1:0]      delta;
   logic                  below;
   logic [POS_W:0]        mult [CELLS_PER_AXIS+1];
   logic [CELLS_PER_AXIS:0] ge;
   logic [POS_W:0]        base;
   logic [OFF_W-1:0]      offset;
   logic                  in_frame;

   // ge[k] is a thermometer: distance reaches k pitches. The cell start is the
   // multiple at the top of the thermometer, picked by a one-hot OR mux.
   always_comb begin
      below = pos < origin;
      delta = pos - origin;
      for (int k = 0; k <= CELLS_PER_AXIS; k++) begin
         mult[k] = (POS_W+1)'(pitch) * (POS_W+1)'(k);
         ge[k]   = {1'b0, delta} >= mult[k];
      end
      base = '0;
      for (int k = 0; k < CELLS_PER_AXIS; k++) begin
         if (ge[k] && !ge[k+1]) begin
            base = base | mult[k];
         end
      end
      in_frame   = !below && !ge[CELLS_PER_AXIS];
      offset     = OFF_W'({1'b0, delta} - base);
      loc.offset = offset;
      loc.ok     = in_frame && ((PITCH_W'(offset) + PITCH_W'(1)) < pitch);
   end

endmodule

`default_nettype wire

### hw/rtl/gbb_tracker.sv
// ----------------------------------------------------------------------------
// gbb_tracker
// Running min/max of ink offsets and the result register. A last pixel is
// folded in first, then the box is registered and the trackers restart.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  gbb_pkg::pix_type                  in_pix,
   output logic                              in_ready,
   input  logic                              restart,
   input  logic [gbb_pkg::PITCH_W-1:0]       restart_pitch_x,
   input  logic [gbb_pkg::PITCH_W-1:0]       restart_pitch_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gbb_pkg::OFF_W-1:0]         rsp_box_x0,
   output logic [gbb_pkg::OFF_W-1:0]         rsp_box_y0,
   output logic signed [gbb_pkg::SIZE_W-1:0] rsp_box_width,
   output logic signed [gbb_pkg::SIZE_W-1:0] rsp_box_height
);
   import gbb_pkg::*;

   logic [OFF_W-1:0]  min_col_ff, min_col_in, min_row_ff, min_row_in;
   logic [OFF_W-1:0]  max_col_ff, max_col_in, max_row_ff, max_row_in;
   logic [OFF_W-1:0]  min_col_upd, min_row_upd, max_col_upd, max_row_upd;
   logic [OFF_W-1:0]  init_col, init_row;
   logic              out_free, fire, emit;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  box_x0_ff, box_x0_in, box_y0_ff, box_y0_in;
   logic [SIZE_W-1:0] box_w_ff, box_w_in, box_h_ff, box_h_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   // only a last pixel needs room in the result register
   assign in_ready = !in_pix.last || out_free;
   assign fire     = in_valid && in_ready;
   assign emit     = fire && in_pix.last;

   assign init_col = OFF_W'(restart_pitch_x - PITCH_W'(2));
   assign init_row = OFF_W'(restart_pitch_y - PITCH_W'(2));

   always_comb begin
      min_col_upd = min_col_ff;
      min_row_upd = min_row_ff;
      max_col_upd = max_col_ff;
      max_row_upd = max_row_ff;
      if (in_pix.hit) begin
         if (in_pix.col < min_col_ff) min_col_upd = in_pix.col;
         if (in_pix.row < min_row_ff) min_row_upd = in_pix.row;
         if (in_pix.col > max_col_ff) max_col_upd = in_pix.col;
         if (in_pix.row > max_row_ff) max_row_upd = in_pix.row;
      end
   end

   always_comb begin
      min_col_in = min_col_ff;
      min_row_in = min_row_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (restart || emit) begin
         min_col_in = init_col;
         min_row_in = init_row;
         max_col_in = '0;
         max_row_in = '0;
      end else if (fire) begin
         min_col_in = min_col_upd;
         min_row_in = min_row_upd;
         max_col_in = max_col_upd;
         max_row_in = max_row_upd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      box_x0_in    = box_x0_ff;
      box_y0_in    = box_y0_ff;
      box_w_in     = box_w_ff;
      box_h_in     = box_h_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         box_x0_in    = min_col_upd;
         box_y0_in    = min_row_upd;
         box_w_in     = SIZE_W'(max_col_upd) - SIZE_W'(min_col_upd) + SIZE_W'(1);
         box_h_in     = SIZE_W'(max_row_upd) - SIZE_W'(min_row_upd) + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_col_ff   <= OFF_W'(PITCH_RESET - PITCH_W'(2));
         min_row_ff   <= OFF_W'(PITCH_RESET - PITCH_W'(2));
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_x0_ff <= box_x0_in;
      box_y0_ff <= box_y0_in;
      box_w_ff  <= box_w_in;
      box_h_ff  <= box_h_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_x0     = box_x0_ff;
   assign rsp_box_y0     = box_y0_ff;
   assign rsp_box_width  = box_w_ff;
   assign rsp_box_height = box_h_ff;

endmodule

`default_nettype wire

### hw/rtl/glyph_grid_ink_bounding_box.sv
// ----------------------------------------------------------------------------
// glyph_grid_ink_bounding_box
// Union ink bounding box over a 16 by 16 grid of glyph cells.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock, back to back, unless a last pixel waits on
// the result register. A pixel passes an input register, a grid-placement
// stage (a compare against seventeen pitch multiples, 0 to 16, per axis), the
// located pixel register and the min/max tracker with its result register.
// Only a word with last_pixel set needs the result register free; other
// pixels keep flowing while a box waits on rsp_ready. Any CSR write restarts
// the trackers; write CSRs only while the block is idle.
`default_nettype none

module glyph_grid_ink_bounding_box (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_pixel,
   input  logic [gbb_pkg::POS_W-1:0]             req_pos_x,
   input  logic [gbb_pkg::POS_W-1:0]             req_pos_y,
   input  logic                                  req_last_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gbb_pkg::OFF_W-1:0]             rsp_box_x0,
   output logic [gbb_pkg::OFF_W-1:0]             rsp_box_y0,
   output logic signed [gbb_pkg::SIZE_W-1:0]     rsp_box_width,
   output logic signed [gbb_pkg::SIZE_W-1:0]     rsp_box_height,
   input  logic                                  csr_we,
   input  logic [gbb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gbb_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import gbb_pkg::*;

   // configuration, pitches kept already clamped
   logic [POS_W-1:0]   frame_x0_ff, frame_x0_in, frame_y0_ff, frame_y0_in;
   logic [PITCH_W-1:0] pitch_x_ff, pitch_x_in, pitch_y_ff, pitch_y_in;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_pixel_ff, s1_last_ff;
   logic [POS_W-1:0]   s1_x_ff, s1_y_ff;
   logic               s1_load;

   // located pixel register
   logic               s2_valid_ff, s2_valid_in;
   pix_type            s2_pix_ff, s2_pix_in;
   logic               s2_free, s1_move;

   loc_type            loc_x, loc_y;
   logic               tr_ready;

   always_comb begin
      frame_x0_in = frame_x0_ff;
      frame_y0_in = frame_y0_ff;
      pitch_x_in  = pitch_x_ff;
      pitch_y_in  = pitch_y_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_X0: frame_x0_in = csr_wdata[POS_W-1:0];
            CSR_FRAME_Y0: frame_y0_in = csr_wdata[POS_W-1:0];
            CSR_PITCH_X:  pitch_x_in  = eff_pitch(csr_wdata[PITCH_W-1:0]);
            CSR_PITCH_Y:  pitch_y_in  = eff_pitch(csr_wdata[PITCH_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_x0_ff <= '0;
         frame_y0_ff <= '0;
         pitch_x_ff  <= PITCH_RESET;
         pitch_y_ff  <= PITCH_RESET;
      end else begin
         frame_x0_ff <= frame_x0_in;
         frame_y0_ff <= frame_y0_in;
         pitch_x_ff  <= pitch_x_in;
         pitch_y_ff  <= pitch_y_in;
      end
   end

   // pipeline handshake
   assign s2_free     = !s2_valid_ff || tr_ready;
   assign s1_move     = s1_valid_ff && s2_free;
   assign req_ready   = !s1_valid_ff || s2_free;
   assign s1_load     = req_valid && req_ready;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s1_move || (s2_valid_ff && !tr_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pixel_ff <= req_pixel;
         s1_last_ff  <= req_last_pixel;
         s1_x_ff     <= req_pos_x;
         s1_y_ff     <= req_pos_y;
      end
      if (s1_move) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

   gbb_locate u_locate_x (
      .pos    (s1_x_ff),
      .origin (frame_x0_ff),
      .pitch  (pitch_x_ff),
      .loc    (loc_x)
   );

   gbb_locate u_locate_y (
      .pos    (s1_y_ff),
      .origin (frame_y0_ff),
      .pitch  (pitch_y_ff),
      .loc    (loc_y)
   );

   always_comb begin
      s2_pix_in.hit  = s1_pixel_ff && loc_x.ok && loc_y.ok;
      s2_pix_in.last = s1_last_ff;
      s2_pix_in.col  = loc_x.offset;
      s2_pix_in.row  = loc_y.offset;
   end

   gbb_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_valid_ff),
      .in_pix          (s2_pix_ff),
      .in_ready        (tr_ready),
      .restart         (csr_we),
      .restart_pitch_x (pitch_x_in),
      .restart_pitch_y (pitch_y_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_box_x0      (rsp_box_x0),
      .rsp_box_y0      (rsp_box_y0),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height)
   );

   // a new box word only follows a last pixel leaving the tracker stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s2_valid_ff && s2_pix_ff.last))
      else $error("box word without a last pixel");

   // ordinary pixels never wait on the result side
   a_pixel_no_stall: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_pix_ff.last |-> tr_ready)
      else $error("ordinary pixel stalled in tracker stage");

   // input only blocks when both stages hold a word
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff && s2_pix_ff.last && rsp_valid)
      else $error("input blocked with room in the pipeline");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> pitch_x_ff >= PITCH_MIN && pitch_x_ff <= PITCH_MAX &&
                 pitch_y_ff >= PITCH_MIN && pitch_y_ff <= PITCH_MAX)
      else $error("pitch register out of range");

endmodule

`default_nettype wire

### bench/glyph_grid_ink_bounding_box_tb.sv
// ----------------------------------------------------------------------------
// glyph_grid_ink_bounding_box_tb
// Self-checking bench for the glyph grid ink bounding box.
// ----------------------------------------------------------------------------
// Streams pixel words through the request channel and predicts each box word
// with a local model of the grid placement and min/max trackers. Directed
// tests hit the reset settings, frame edges, pitch clamping and tracker
// restart on register writes. The random test then runs raster windows and
// loose noise words under several grid settings. The sender works in bursts
// and the receiver stalls on its own pattern.
`default_nettype none

module glyph_grid_ink_bounding_box_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbb_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int DRAIN_WAIT  = 8;       // margin for the pipeline to go quiet
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int PHASES      = 10;

   typedef struct packed {
      logic [OFF_W-1:0]  x0;
      logic [OFF_W-1:0]  y0;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic             req_pixel      = 1'b0;
   logic [POS_W-1:0] req_pos_x      = '0;
   logic [POS_W-1:0] req_pos_y      = '0;
   logic             req_last_pixel = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [OFF_W-1:0]         rsp_box_x0;
   logic [OFF_W-1:0]         rsp_box_y0;
   logic signed [SIZE_W-1:0] rsp_box_width;
   logic signed [SIZE_W-1:0] rsp_box_height;

   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_FRAME_X0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   glyph_grid_ink_bounding_box i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_x0     (rsp_box_x0),
      .rsp_box_y0     (rsp_box_y0),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Ink box predictor
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]   grid_x0    = '0;
   logic [POS_W-1:0]   grid_y0    = '0;
   logic [PITCH_W-1:0] grid_pitch_x = PITCH_RESET;
   logic [PITCH_W-1:0] grid_pitch_y = PITCH_RESET;
   int ink_min_col = 14;
   int ink_min_row = 14;
   int ink_max_col = 0;
   int ink_max_row = 0;

   box_type expected_boxes[$];

   int items_sent    = 0;
   int boxes_checked = 0;
   int settings_used = 0;
   int err_count     = 0;
   int burst_left    = 0;

   function automatic int clamp_pitch(input logic [PITCH_W-1:0] p);
      if (p < 2) return 2;
      if (p > 256) return 256;
      return int'(p);
   endfunction

   function automatic void restart_trackers();
      ink_min_col = clamp_pitch(grid_pitch_x) - 2;
      ink_min_row = clamp_pitch(grid_pitch_y) - 2;
      ink_max_col = 0;
      ink_max_row = 0;
   endfunction

   // True when pos lands inside a cell and off its last column/row.
   function automatic bit place_on_grid(input int pos, input int origin, input int pitch,
                                        output int offset);
      int d;
      int c;
      offset = 0;
      if (pos < origin) return 0;
      d = pos - origin;
      c = d / pitch;
      if (c >= CELLS_PER_AXIS) return 0;
      offset = d - c * pitch;
      return offset < pitch - 1;
   endfunction

   function automatic void track_pixel(input logic pix, input logic [POS_W-1:0] x,
                                       input logic [POS_W-1:0] y, input logic last);
      int      col;
      int      row;
      bit      in_x;
      bit      in_y;
      box_type box;
      in_x = place_on_grid(int'(x), int'(grid_x0), clamp_pitch(grid_pitch_x), col);
      in_y = place_on_grid(int'(y), int'(grid_y0), clamp_pitch(grid_pitch_y), row);
      if (pix && in_x && in_y) begin
         if (col < ink_min_col) ink_min_col = col;
         if (row < ink_min_row) ink_min_row = row;
         if (col > ink_max_col) ink_max_col = col;
         if (row > ink_max_row) ink_max_row = row;
      end
      if (last) begin
         box.x0     = OFF_W'(ink_min_col);
         box.y0     = OFF_W'(ink_min_row);
         box.width  = SIZE_W'(ink_max_col - ink_min_col + 1);
         box.height = SIZE_W'(ink_max_row - ink_min_row + 1);
         expected_boxes.push_back(box);
         restart_trackers();
      end
   endfunction

   function automatic void flag_error(input string text);
      err_count++;
      if (err_count <= 10) $display("ERROR: %s", text);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker and receiver stall pattern
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      box_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_boxes.size() == 0) begin
            flag_error($sformatf("box word with nothing expected: x0=%0d y0=%0d w=%0d h=%0d",
                                 rsp_box_x0, rsp_box_y0, rsp_box_width, rsp_box_height));
         end else begin
            want = expected_boxes.pop_front();
            boxes_checked++;
            if (rsp_box_x0 !== want.x0)
               flag_error($sformatf("box %0d box_x0: expected %0d, got %0d",
                                    boxes_checked, want.x0, rsp_box_x0));
            if (rsp_box_y0 !== want.y0)
               flag_error($sformatf("box %0d box_y0: expected %0d, got %0d",
                                    boxes_checked, want.y0, rsp_box_y0));
            if (rsp_box_width !== want.width)
               flag_error($sformatf("box %0d box_width: expected %0d, got %0d",
                                    boxes_checked, $signed(want.width), rsp_box_width));
            if (rsp_box_height !== want.height)
               flag_error($sformatf("box %0d box_height: expected %0d, got %0d",
                                    boxes_checked, $signed(want.height), rsp_box_height));
         end
      end
   end

   int cycle_count = 0;
   int rx_mode     = 0;
   int rx_hold     = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d boxes outstanding",
                  cycle_count, expected_boxes.size());
         $display("** glyph_grid_ink_bounding_box: FAILED **");
         $finish;
      end
      // switch between always-ready, light random stalls and long stalls
      if (cycle_count % 200 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_hold != 0) begin
               rx_hold--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               rx_hold = $urandom_range(1, 12);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic send_pixel(input logic pix, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_pixel      <= pix;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_last_pixel <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_pixel(pix, x, y, last);
      items_sent++;
   endtask

   // Drop valid, drain every box word, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_FRAME_X0: grid_x0      = data;
         CSR_FRAME_Y0: grid_y0      = data;
         CSR_PITCH_X:  grid_pitch_x = data[PITCH_W-1:0];
         CSR_PITCH_Y:  grid_pitch_y = data[PITCH_W-1:0];
         default: ;
      endcase
      restart_trackers();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_pitch_word();
      logic [PITCH_W-1:0] p;
      case ($urandom_range(0, 5))
         0:       p = PITCH_W'($urandom_range(0, 1));
         1:       p = PITCH_W'($urandom_range(257, 511));
         2:       p = PITCH_W'($urandom_range(250, 256));
         default: p = PITCH_W'($urandom_range(2, 8));
      endcase
      // upper bits are not part of the pitch register
      return {3'($urandom_range(0, 7)), p};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_origin();
      if ($urandom_range(0, 3) == 0) return CSR_DATA_W'($urandom_range(0, 4095));
      return CSR_DATA_W'($urandom_range(0, 64));
   endfunction

   // Pick a window start near the frame, often right at a cell boundary.
   function automatic int window_start(input int origin, input int pitch, input int span);
      int s;
      if ($urandom_range(0, 1) == 0)
         s = origin + int'($urandom_range(0, 16)) * pitch + int'($urandom_range(0, 5)) - 3;
      else
         s = origin + int'($urandom_range(0, 16 * pitch)) - 2;
      if (s < 0) s = 0;
      if (s > 4096 - span) s = 4096 - span;
      return s;
   endfunction

   // One raster image: a small window with random ink, last on its final pixel.
   task automatic send_image();
      int w;
      int h;
      int sx;
      int sy;
      int ink_pct;
      w  = $urandom_range(1, 10);
      h  = $urandom_range(1, 6);
      sx = window_start(int'(grid_x0), clamp_pitch(grid_pitch_x), w);
      sy = window_start(int'(grid_y0), clamp_pitch(grid_pitch_y), h);
      case ($urandom_range(0, 3))
         0: ink_pct = 0;
         1: ink_pct = 10;
         2: ink_pct = 50;
         default: ink_pct = 90;
      endcase
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            send_pixel($urandom_range(0, 99) < ink_pct, POS_W'(sx + c), POS_W'(sy + r),
                       (r == h - 1) && (c == w - 1));
         end
      end
   endtask

   task automatic send_noise();
      int n;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(0, 1) == 0) begin
            x = POS_W'($urandom_range(0, 4095));
            y = POS_W'($urandom_range(0, 4095));
         end else begin
            x = grid_x0 + POS_W'($urandom_range(0, 40));
            y = grid_y0 + POS_W'($urandom_range(0, 40));
         end
         send_pixel(1'($urandom_range(0, 1)), x, y, $urandom_range(0, 5) == 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_settings();
      // blank image, then ink in two cells plus one on a last column
      send_pixel(1'b0, 12'd5, 12'd5, 1'b1);
      send_pixel(1'b1, 12'd3, 12'd4, 1'b0);
      send_pixel(1'b1, 12'd20, 12'd37, 1'b0);
      send_pixel(1'b1, 12'd15, 12'd15, 1'b1);
   endtask

   task automatic test_frame_edges();
      write_reg(CSR_FRAME_X0, 12'd100);
      write_reg(CSR_FRAME_Y0, 12'd4000);
      send_pixel(1'b1, 12'd99, 12'd4000, 1'b0);     // left of frame
      send_pixel(1'b1, 12'd100, 12'd3999, 1'b0);    // above frame
      send_pixel(1'b1, 12'd356, 12'd4000, 1'b0);    // past last cell
      send_pixel(1'b1, 12'd355, 12'd4000, 1'b0);    // last column of last cell
      send_pixel(1'b1, 12'd354, 12'd4095, 1'b0);    // last row of a cell
      send_pixel(1'b1, 12'd4095, 12'd4095, 1'b0);
      send_pixel(1'b1, 12'd354, 12'd4094, 1'b1);    // last word counts itself
   endtask

   task automatic test_pitch_clamp();
      write_reg(CSR_FRAME_X0, 12'd0);
      write_reg(CSR_FRAME_Y0, 12'd0);
      write_reg(CSR_PITCH_X, 12'd0);
      write_reg(CSR_PITCH_Y, 12'hFFF);
      send_pixel(1'b1, 12'd0, 12'd254, 1'b0);
      send_pixel(1'b1, 12'd31, 12'd0, 1'b0);
      send_pixel(1'b1, 12'd30, 12'd0, 1'b1);
      write_reg(CSR_PITCH_X, 12'd1);
      write_reg(CSR_PITCH_Y, 12'd257);
      send_pixel(1'b0, 12'd0, 12'd0, 1'b1);
   endtask

   task automatic test_write_restarts();
      write_reg(CSR_PITCH_X, 12'd16);
      write_reg(CSR_PITCH_Y, 12'd16);
      send_pixel(1'b1, 12'd1, 12'd1, 1'b0);
      // ink above must be forgotten once the register is rewritten
      write_reg(CSR_FRAME_X0, 12'd0);
      send_pixel(1'b0, 12'd0, 12'd0, 1'b1);
   endtask

   task automatic test_random_images();
      int goal;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_FRAME_X0, 12'd0);
               write_reg(CSR_FRAME_Y0, 12'd0);
               write_reg(CSR_PITCH_X, 12'd2);
               write_reg(CSR_PITCH_Y, 12'd2);
            end
            1: begin
               write_reg(CSR_PITCH_X, 12'd256);
               write_reg(CSR_PITCH_Y, 12'd256);
            end
            2: begin
               write_reg(CSR_FRAME_X0, 12'd4095);
               write_reg(CSR_FRAME_Y0, 12'd4095);
               write_reg(CSR_PITCH_X, 12'd2);
               write_reg(CSR_PITCH_Y, 12'd3);
            end
            default: begin
               write_reg(CSR_FRAME_X0, random_origin());
               write_reg(CSR_FRAME_Y0, random_origin());
               write_reg(CSR_PITCH_X, random_pitch_word());
               write_reg(CSR_PITCH_Y, random_pitch_word());
            end
         endcase
         settings_used++;
         goal = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < goal) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else send_image();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_frame_edges();
      test_pitch_clamp();
      test_write_restarts();
      test_random_images();

      settle();
      if (expected_boxes.size() != 0)
         flag_error($sformatf("%0d box words never arrived", expected_boxes.size()));

      $display("covered %0d pixel words and %0d box words over %0d random grid settings",
               items_sent, boxes_checked, settings_used);
      $display("mismatches: %0d", err_count);
      if (err_count == 0) begin
         $display("** glyph_grid_ink_bounding_box: PASSED **");
      end else begin
         $display("** glyph_grid_ink_bounding_box: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
